// ===== rtl/ppd_pkg.sv =====
// Shared types, constants and rounding helpers for the point-to-primitive distance block.
// Used by ppd_sqrt, ppd_div and point_primitive_distance.
package ppd_pkg;

	localparam int FRAC_BITS = 12;
	localparam int COORD_W   = 20;
	localparam int INNER_W   = 31;
	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 3 * COORD_W;
	localparam int LEN_W     = 19;
	localparam int APT_W     = 28;
	localparam int DIR_W     = 27;
	localparam int NUM_W     = 47;
	localparam int SS_W      = 54;
	localparam int ROOT_W    = SS_W / 2;
	localparam int REM_W     = ROOT_W + 2;
	localparam int DEN_W     = ROOT_W + 1;
	localparam int QUO_W     = 20;

	localparam logic [1:0] FN_PLANE  = 2'd0;
	localparam logic [1:0] FN_CAP    = 2'd1;
	localparam logic [1:0] FN_HOLLOW = 2'd2;
	localparam logic [1:0] FN_BAD    = 2'd3;

	localparam logic [2:0] REG_AXIS   = 3'd0;
	localparam logic [2:0] REG_SIDE   = 3'd1;
	localparam logic [2:0] REG_THIRD  = 3'd2;
	localparam logic [2:0] REG_ORIGIN = 3'd3;
	localparam logic [2:0] REG_ANCHOR = 3'd4;
	localparam logic [2:0] REG_NORMAL = 3'd5;
	localparam logic [2:0] REG_RADIUS = 3'd6;
	localparam logic [2:0] REG_LENGTH = 3'd7;

	localparam logic signed [63:0] INNER_LIM = (64'sd1 <<< (INNER_W - 1)) - 64'sd1;
	localparam logic signed [63:0] COORD_HI  = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam logic signed [63:0] COORD_LO  = -COORD_HI - 64'sd1;
	localparam logic signed [63:0] HALF_LSB  = 64'sd1 <<< (FRAC_BITS - 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [INNER_W-1:0] inner_t;
	typedef logic signed [APT_W-1:0]   apt_t;
	typedef logic signed [DIR_W-1:0]   dir_t;
	typedef logic signed [NUM_W-1:0]   num_t;
	typedef logic [ROOT_W-1:0]         root_t;

	// sideband carried alongside the square root
	typedef struct packed {
		logic [1:0]   func;
		coord_t       pdist;
		coord_t [2:0] pnear;
		coord_t [2:0] fnear;
		apt_t [2:0]   apt;
		num_t [2:0]   pr2;
	} sq_side_t;

	// sideband carried alongside the divider
	typedef struct packed {
		logic [1:0]   func;
		coord_t       pdist;
		coord_t [2:0] pnear;
		coord_t [2:0] fnear;
		apt_t [2:0]   apt;
		root_t        norm;
		logic [2:0]   neg;
	} dv_side_t;

	// scale a product back by FRAC_BITS, round half up
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
		return (v + HALF_LSB) >>> FRAC_BITS;
	endfunction

	// clamp an intermediate to +-(2^30 - 1)
	function automatic inner_t clampw(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (v > INNER_LIM) c = INNER_LIM;
		if (v < -INNER_LIM) c = -INNER_LIM;
		return c[INNER_W-1:0];
	endfunction

	// saturate to the output coordinate range
	function automatic coord_t sat(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (v > COORD_HI) c = COORD_HI;
		if (v < COORD_LO) c = COORD_LO;
		return c[COORD_W-1:0];
	endfunction

endpackage

// ===== rtl/ppd_sqrt.sv =====
// Pipelined floor square root, one result bit per stage, with sideband.
// Depends on ppd_pkg.
module ppd_sqrt import ppd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [SS_W-1:0] ss,
	input  sq_side_t        side_in,
	output logic            out_valid,
	output root_t           root,
	output sq_side_t        side_out
);

	logic            v_s    [ROOT_W];
	logic [REM_W-1:0] rem_s [ROOT_W];
	root_t           root_s [ROOT_W];
	logic [SS_W-1:0] x_s    [ROOT_W];
	sq_side_t        side_s [ROOT_W];

	logic [REM_W-1:0] rem_d  [ROOT_W];
	root_t            root_d [ROOT_W];
	logic [SS_W-1:0]  x_d    [ROOT_W];

	// one digit per stage: shift in two radicand bits, try 4r+1
	always_comb begin
		logic [REM_W-1:0] rin;
		root_t            qin;
		logic [SS_W-1:0]  xin;
		logic [REM_W-1:0] rsh;
		logic [REM_W-1:0] trial;
		for (int i = 0; i < ROOT_W; i++) begin
			if (i == 0) begin
				rin = '0;
				qin = '0;
				xin = ss;
			end else begin
				rin = rem_s[i-1];
				qin = root_s[i-1];
				xin = x_s[i-1];
			end
			rsh   = {rin[REM_W-3:0], xin[SS_W-1 -: 2]};
			trial = {qin, 2'b01};
			x_d[i] = {xin[SS_W-3:0], 2'b00};
			if (rsh >= trial) begin
				rem_d[i]  = rsh - trial;
				root_d[i] = {qin[ROOT_W-2:0], 1'b1};
			end else begin
				rem_d[i]  = rsh;
				root_d[i] = {qin[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROOT_W; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i < ROOT_W; i++) v_s[i] <= v_s[i-1];
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < ROOT_W; i++) side_s[i] <= side_s[i-1];
			for (int i = 0; i < ROOT_W; i++) begin
				rem_s[i]  <= rem_d[i];
				root_s[i] <= root_d[i];
				x_s[i]    <= x_d[i];
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign side_out  = side_s[ROOT_W-1];

endmodule

// ===== rtl/ppd_div.sv =====
// Pipelined three-lane restoring divider (radial scaling), one quotient bit per stage.
// Depends on ppd_pkg.
module ppd_div import ppd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  root_t            norm,
	input  sq_side_t         side_in,
	output logic             out_valid,
	output logic [QUO_W-1:0] quo [3],
	output logic [2:0]       rem_nz,
	output dv_side_t         side_out
);

	logic             v_p;
	logic [DEN_W-1:0] den_p;
	logic [DEN_W-1:0] r_p  [3];
	logic [QUO_W-1:0] ml_p [3];
	dv_side_t         side_p;

	logic             v_s    [QUO_W];
	logic [DEN_W-1:0] den_s  [QUO_W];
	logic [DEN_W-1:0] r_s    [QUO_W][3];
	logic [QUO_W-1:0] q_s    [QUO_W][3];
	logic [QUO_W-1:0] ml_s   [QUO_W][3];
	dv_side_t         side_s [QUO_W];

	logic [DEN_W-1:0] r_d  [QUO_W][3];
	logic [QUO_W-1:0] q_d  [QUO_W][3];
	logic [QUO_W-1:0] ml_d [QUO_W][3];

	logic [DEN_W-1:0] r0_d  [3];
	logic [QUO_W-1:0] ml0_d [3];
	dv_side_t         side0_d;

	// form numerator 2*dir*rad + norm, take sign and magnitude
	always_comb begin
		logic signed [63:0] n;
		logic [63:0]        m;
		side0_d.func  = side_in.func;
		side0_d.pdist = side_in.pdist;
		side0_d.pnear = side_in.pnear;
		side0_d.fnear = side_in.fnear;
		side0_d.apt   = side_in.apt;
		side0_d.norm  = norm;
		for (int k = 0; k < 3; k++) begin
			n = 64'($signed(side_in.pr2[k])) + 64'(norm);
			side0_d.neg[k] = n[63];
			m = n[63] ? 64'(-n) : 64'(n);
			r0_d[k]  = DEN_W'(m[NUM_W-1:QUO_W]);
			ml0_d[k] = m[QUO_W-1:0];
		end
	end

	// one quotient bit per stage and lane
	always_comb begin
		logic [DEN_W-1:0] rin;
		logic [QUO_W-1:0] qin;
		logic [QUO_W-1:0] mlin;
		logic [DEN_W-1:0] dn;
		logic [DEN_W:0]   rsh;
		for (int j = 0; j < QUO_W; j++) begin
			for (int k = 0; k < 3; k++) begin
				if (j == 0) begin
					rin  = r_p[k];
					qin  = '0;
					mlin = ml_p[k];
					dn   = den_p;
				end else begin
					rin  = r_s[j-1][k];
					qin  = q_s[j-1][k];
					mlin = ml_s[j-1][k];
					dn   = den_s[j-1];
				end
				rsh = {rin, mlin[QUO_W-1]};
				ml_d[j][k] = {mlin[QUO_W-2:0], 1'b0};
				if (rsh >= {1'b0, dn}) begin
					r_d[j][k] = DEN_W'(rsh - {1'b0, dn});
					q_d[j][k] = {qin[QUO_W-2:0], 1'b1};
				end else begin
					r_d[j][k] = rsh[DEN_W-1:0];
					q_d[j][k] = {qin[QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
			for (int j = 0; j < QUO_W; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			v_p    <= in_valid;
			v_s[0] <= v_p;
			for (int j = 1; j < QUO_W; j++) v_s[j] <= v_s[j-1];
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			den_p     <= {norm, 1'b0};
			side_p    <= side0_d;
			den_s[0]  <= den_p;
			side_s[0] <= side_p;
			for (int j = 1; j < QUO_W; j++) begin
				den_s[j]  <= den_s[j-1];
				side_s[j] <= side_s[j-1];
			end
			for (int k = 0; k < 3; k++) begin
				r_p[k]  <= r0_d[k];
				ml_p[k] <= ml0_d[k];
				for (int j = 0; j < QUO_W; j++) begin
					r_s[j][k]  <= r_d[j][k];
					q_s[j][k]  <= q_d[j][k];
					ml_s[j][k] <= ml_d[j][k];
				end
			end
		end
	end

	assign out_valid = v_s[QUO_W-1];
	assign side_out  = side_s[QUO_W-1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			quo[k]    = q_s[QUO_W-1][k];
			rem_nz[k] = (r_s[QUO_W-1][k] != '0);
		end
	end

endmodule

// ===== rtl/point_primitive_distance.sv =====
// Pipeline: 6 front stages, 27 root stages, 21 divider stages and 1 output register;
// throughput one beat per cycle while the output beat is not stalled.
// The whole pipeline advances together; it holds only while the output beat is stalled.
// Reset clears all valid bits and loads the default pose: identity rotation, zero origin,
// plane normal along z, zero radius and length.
// Top level; depends on ppd_pkg, ppd_sqrt and ppd_div.
module point_primitive_distance import ppd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [REG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [COORD_W-1:0] point_x,
	input  logic [COORD_W-1:0] point_y,
	input  logic [COORD_W-1:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COORD_W-1:0] signed_distance,
	output logic [COORD_W-1:0] near_x,
	output logic [COORD_W-1:0] near_y,
	output logic [COORD_W-1:0] near_z,
	output logic               on_axis,
	output logic               bad_kind
);

	// configuration registers
	logic [REG_W-1:0] axis_q, side_q, third_q, origin_q, anchor_q, normal_q;
	logic [LEN_W-1:0] radius_q, length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q   <= REG_W'(64'd4096);
			side_q   <= REG_W'(64'd4294967296);
			third_q  <= REG_W'(64'd4503599627370496);
			origin_q <= '0;
			anchor_q <= '0;
			normal_q <= REG_W'(64'd4503599627370496);
			radius_q <= '0;
			length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIS:   axis_q   <= cfg_wdata;
				REG_SIDE:   side_q   <= cfg_wdata;
				REG_THIRD:  third_q  <= cfg_wdata;
				REG_ORIGIN: origin_q <= cfg_wdata;
				REG_ANCHOR: anchor_q <= cfg_wdata;
				REG_NORMAL: normal_q <= cfg_wdata;
				REG_RADIUS: radius_q <= cfg_wdata[LEN_W-1:0];
				REG_LENGTH: length_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack pose fields
	coord_t col [3][3];
	coord_t org [3];
	coord_t anc [3];
	coord_t dnl [3];
	logic signed [INNER_W-1:0] half_c;
	logic signed [LEN_W:0]     rad_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			col[0][k] = axis_q[k*COORD_W +: COORD_W];
			col[1][k] = side_q[k*COORD_W +: COORD_W];
			col[2][k] = third_q[k*COORD_W +: COORD_W];
			org[k]    = origin_q[k*COORD_W +: COORD_W];
			anc[k]    = anchor_q[k*COORD_W +: COORD_W];
			dnl[k]    = normal_q[k*COORD_W +: COORD_W];
		end
		half_c = INNER_W'(({1'b0, length_q} + 20'd1) >> 1);
		rad_c  = {1'b0, radius_q};
	end

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	coord_t pin [3];
	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;

	// stage 1: rotation products and axial products
	logic                v_s1;
	logic [1:0]          func_s1;
	coord_t              p_s1  [3];
	logic signed [39:0]  pn_s1 [3][3];
	logic signed [39:0]  pa_s1 [3][3];
	logic signed [40:0]  pc_s1 [3];

	always_ff @(posedge clk) begin
		logic signed [COORD_W:0] dc;
		if (en) begin
			func_s1 <= func;
			for (int k = 0; k < 3; k++) begin
				p_s1[k] <= pin[k];
				dc = COORD_W'(0) + (COORD_W+1)'(64'(pin[k]) - 64'(org[k]));
				pc_s1[k] <= dc * col[0][k];
				for (int j = 0; j < 3; j++) begin
					pn_s1[j][k] <= col[j][k] * dnl[j];
					pa_s1[j][k] <= col[j][k] * anc[j];
				end
			end
		end
	end

	// stage 2: rotated normal, world anchor, clamped axial coordinate
	logic        v_s2;
	logic [1:0]  func_s2;
	coord_t      p_s2  [3];
	inner_t      nw_s2 [3];
	inner_t      aw_s2 [3];
	coord_t      z_s2;

	always_ff @(posedge clk) begin
		inner_t zz;
		if (en) begin
			func_s2 <= func_s1;
			for (int k = 0; k < 3; k++) begin
				p_s2[k]  <= p_s1[k];
				nw_s2[k] <= clampw(rnd(64'(pn_s1[0][k]) + 64'(pn_s1[1][k]) + 64'(pn_s1[2][k])));
				aw_s2[k] <= clampw(64'(clampw(rnd(64'(pa_s1[0][k]) + 64'(pa_s1[1][k])
					+ 64'(pa_s1[2][k])))) + 64'(org[k]));
			end
			zz = clampw(rnd(64'(pc_s1[0]) + 64'(pc_s1[1]) + 64'(pc_s1[2])));
			if (zz > half_c) zz = half_c;
			if (zz < -half_c) zz = -half_c;
			z_s2 <= zz[COORD_W-1:0];
		end
	end

	// stage 3: plane dot products, axis point products
	logic               v_s3;
	logic [1:0]         func_s3;
	coord_t             p_s3  [3];
	inner_t             nw_s3 [3];
	logic signed [61:0] pd_s3 [3];
	logic signed [39:0] pz_s3 [3];

	always_ff @(posedge clk) begin
		inner_t df;
		if (en) begin
			func_s3 <= func_s2;
			for (int k = 0; k < 3; k++) begin
				p_s3[k]  <= p_s2[k];
				nw_s3[k] <= nw_s2[k];
				df = clampw(64'(p_s2[k]) - 64'(aw_s2[k]));
				pd_s3[k] <= df * nw_s2[k];
				pz_s3[k] <= z_s2 * col[0][k];
			end
		end
	end

	// stage 4: plane distance, axis point, radial vector
	logic        v_s4;
	logic [1:0]  func_s4;
	coord_t      p_s4   [3];
	inner_t      nw_s4  [3];
	inner_t      pdist_s4;
	apt_t        apt_s4 [3];
	dir_t        dir_s4 [3];

	always_ff @(posedge clk) begin
		logic signed [63:0] ap;
		if (en) begin
			func_s4  <= func_s3;
			pdist_s4 <= clampw(rnd(64'(pd_s3[0]) + 64'(pd_s3[1]) + 64'(pd_s3[2])));
			for (int k = 0; k < 3; k++) begin
				p_s4[k]   <= p_s3[k];
				nw_s4[k]  <= nw_s3[k];
				ap = 64'(clampw(64'(org[k]) + rnd(pz_s3[k])));
				apt_s4[k] <= ap[APT_W-1:0];
				dir_s4[k] <= DIR_W'(64'(clampw(64'(p_s3[k]) - ap)));
			end
		end
	end

	// stage 5: squares, radius scaling, plane correction products
	logic               v_s5;
	logic [1:0]         func_s5;
	coord_t             p_s5   [3];
	inner_t             pdist_s5;
	apt_t               apt_s5 [3];
	logic signed [61:0] pm_s5  [3];
	logic [51:0]        sq_s5  [3];
	num_t               pr2_s5 [3];
	logic signed [39:0] fb_s5  [3];

	always_ff @(posedge clk) begin
		logic signed [53:0] sqt;
		logic signed [47:0] prt;
		if (en) begin
			func_s5  <= func_s4;
			pdist_s5 <= pdist_s4;
			for (int k = 0; k < 3; k++) begin
				p_s5[k]   <= p_s4[k];
				apt_s5[k] <= apt_s4[k];
				pm_s5[k]  <= pdist_s4 * nw_s4[k];
				sqt = dir_s4[k] * dir_s4[k];
				sq_s5[k]  <= sqt[51:0];
				prt = dir_s4[k] * rad_c;
				pr2_s5[k] <= {prt[NUM_W-2:0], 1'b0};
				fb_s5[k]  <= col[1][k] * rad_c;
			end
		end
	end

	// stage 6: sum of squares, plane result, fallback near point
	logic     v_s6;
	logic [SS_W-1:0] ss_s6;
	sq_side_t side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s6 <= SS_W'(sq_s5[0]) + SS_W'(sq_s5[1]) + SS_W'(sq_s5[2]);
			side_s6.func  <= func_s5;
			side_s6.pdist <= sat(64'(pdist_s5));
			for (int k = 0; k < 3; k++) begin
				side_s6.pnear[k] <= sat(64'(p_s5[k]) - rnd(pm_s5[k]));
				side_s6.fnear[k] <= sat(64'(apt_s5[k]) + rnd(fb_s5[k]));
				side_s6.apt[k]   <= apt_s5[k];
				side_s6.pr2[k]   <= pr2_s5[k];
			end
		end
	end

	// front-stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// radial norm
	logic     sq_valid;
	root_t    norm;
	sq_side_t sq_side;

	ppd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.ss       (ss_s6),
		.side_in  (side_s6),
		.out_valid(sq_valid),
		.root     (norm),
		.side_out (sq_side)
	);

	// radial scaling by radius over norm
	logic             dv_valid;
	logic [QUO_W-1:0] quo [3];
	logic [2:0]       rem_nz;
	dv_side_t         dv_side;

	ppd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.norm     (norm),
		.side_in  (sq_side),
		.out_valid(dv_valid),
		.quo      (quo),
		.rem_nz   (rem_nz),
		.side_out (dv_side)
	);

	// select result by kind
	coord_t dist_d;
	coord_t near_d [3];
	logic   axis_d;
	logic   bad_d;

	always_comb begin
		logic signed [63:0] qs;
		logic signed [63:0] cd;
		dist_d = '0;
		axis_d = 1'b0;
		bad_d  = 1'b0;
		qs     = '0;
		for (int k = 0; k < 3; k++) near_d[k] = '0;
		cd = 64'(dv_side.norm) - 64'(radius_q);
		case (dv_side.func)
			FN_PLANE: begin
				dist_d = dv_side.pdist;
				for (int k = 0; k < 3; k++) near_d[k] = dv_side.pnear[k];
			end
			FN_CAP, FN_HOLLOW: begin
				dist_d = (dv_side.func == FN_CAP) ? sat(cd) : sat(-cd);
				axis_d = (dv_side.norm == '0);
				for (int k = 0; k < 3; k++) begin
					if (dv_side.neg[k]) qs = -(64'(quo[k]) + 64'(rem_nz[k]));
					else qs = 64'(quo[k]);
					if (axis_d) near_d[k] = dv_side.fnear[k];
					else near_d[k] = sat(64'($signed(dv_side.apt[k])) + qs);
				end
			end
			default: bad_d = 1'b1;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			signed_distance <= dist_d;
			near_x   <= near_d[0];
			near_y   <= near_d[1];
			near_z   <= near_d[2];
			on_axis  <= axis_d;
			bad_kind <= bad_d;
		end
	end

	// an unsupported kind carries no distance and never the axis flag
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_kind |-> signed_distance == '0 && !on_axis)
		else $error("bad kind beat carries data");

	// on the axis the distance is exactly plus or minus the radius
	a_axis_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && on_axis |->
		$signed(signed_distance) == $signed(rad_c) || $signed(signed_distance) == -$signed(rad_c))
		else $error("axis fallback distance mismatch");

	// a stalled output beat stays valid in the next cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled output beat dropped");

endmodule

// ===== bench/point_primitive_distance_tb.sv =====
// Self-checking bench for point_primitive_distance: plane, capsule, hollow capsule and unsupported
// queries under several pose settings, with random input gaps and random output stalls.
// Depends on ppd_pkg and the point_primitive_distance RTL.
module point_primitive_distance_tb;
	import ppd_pkg::*;

	typedef struct {
		logic [1:0]  fn;
		logic [19:0] x, y, z;
	} query_t;

	typedef struct {
		logic [19:0] sd, nx, ny, nz;
		logic        axis_hit, bad;
	} answer_t;

	logic              clk, arst_n;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [REG_W-1:0]  cfg_wdata;
	logic              in_valid, in_stall, out_valid, out_stall;
	logic [1:0]        func;
	logic [19:0]       point_x, point_y, point_z;
	logic [19:0]       signed_distance, near_x, near_y, near_z;
	logic              on_axis, bad_kind;

	query_t  pending_q[$];
	answer_t answer_q[$];
	logic [59:0] pose_reg[8];
	int errors, n_results, n_axis, n_bad, gap_left, hold_left;
	bit hold_done;
	int kind_cnt[4];

	point_primitive_distance u_dut (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// sign extend one packed 20-bit field
	function automatic longint field(logic [59:0] r, int k);
		logic [19:0] f;
		f = r[k*20 +: 20];
		return {{44{f[19]}}, f};
	endfunction

	function automatic longint clip30(longint v);
		longint lim;
		lim = (longint'(1) <<< 30) - 1;
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint round_q(longint v);
		return (v + 2048) >>> 12;
	endfunction

	function automatic longint floor_quo(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [19:0] sat20(longint v);
		if (v > 524287) v = 524287;
		if (v < -524288) v = -524288;
		return v[19:0];
	endfunction

	// rotate a local vector by the pose columns
	function automatic void to_world(longint c[3][3], longint l[3], output longint w[3]);
		for (int k = 0; k < 3; k++)
			w[k] = clip30(round_q(c[0][k]*l[0] + c[1][k]*l[1] + c[2][k]*l[2]));
	endfunction

	// closest surface point and signed distance for one query
	function automatic answer_t surface_distance(query_t q);
		answer_t a;
		longint col[3][3], org[3], p[3], nr[3], an[3], dn[3], aw[3], nw[3], apt[3], dir[3];
		longint sdist, acc, z, rad, half, norm;
		logic [63:0] ss;
		a.axis_hit = 0;
		a.bad = 0;
		sdist = 0;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) col[j][k] = field(pose_reg[j], k);
			org[k] = field(pose_reg[REG_ORIGIN], k);
			an[k] = field(pose_reg[REG_ANCHOR], k);
			dn[k] = field(pose_reg[REG_NORMAL], k);
		end
		p[0] = {{44{q.x[19]}}, q.x};
		p[1] = {{44{q.y[19]}}, q.y};
		p[2] = {{44{q.z[19]}}, q.z};
		if (q.fn == FN_BAD) begin
			a.sd = 0; a.nx = 0; a.ny = 0; a.nz = 0; a.bad = 1;
			return a;
		end
		if (q.fn == FN_PLANE) begin
			to_world(col, dn, nw);
			to_world(col, an, aw);
			acc = 0;
			for (int k = 0; k < 3; k++) begin
				aw[k] = clip30(aw[k] + org[k]);
				acc += clip30(p[k] - aw[k]) * nw[k];
			end
			sdist = clip30(round_q(acc));
			for (int k = 0; k < 3; k++) nr[k] = p[k] - round_q(sdist * nw[k]);
		end else begin
			rad = pose_reg[REG_RADIUS][18:0];
			half = (longint'(pose_reg[REG_LENGTH][18:0]) + 1) >>> 1;
			acc = 0;
			ss = 0;
			for (int k = 0; k < 3; k++) acc += clip30(p[k] - org[k]) * col[0][k];
			z = clip30(round_q(acc));
			if (z > half) z = half;
			if (z < -half) z = -half;
			for (int k = 0; k < 3; k++) begin
				apt[k] = clip30(org[k] + round_q(z * col[0][k]));
				dir[k] = clip30(p[k] - apt[k]);
				ss += dir[k] * dir[k];
			end
			norm = root_floor(ss);
			sdist = (q.fn == FN_CAP) ? norm - rad : rad - norm;
			if (ss != 0) begin
				for (int k = 0; k < 3; k++)
					nr[k] = apt[k] + floor_quo(2 * dir[k] * rad + norm, 2 * norm);
			end else begin
				a.axis_hit = 1;
				for (int k = 0; k < 3; k++) nr[k] = apt[k] + round_q(col[1][k] * rad);
			end
		end
		a.sd = sat20(sdist);
		a.nx = sat20(nr[0]);
		a.ny = sat20(nr[1]);
		a.nz = sat20(nr[2]);
		return a;
	endfunction

	// sender: offer queued queries with random gaps, predict on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= '0; point_x <= '0; point_y <= '0; point_z <= '0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				answer_q.push_back(surface_distance('{func, point_x, point_y, point_z}));
				kind_cnt[func]++;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				query_t q;
				q = pending_q.pop_front();
				func <= q.fn; point_x <= q.x; point_y <= q.y; point_z <= q.z;
				in_valid <= 1'b1;
				if ($urandom_range(0, 99) < 60) gap_left <= 0;
				else if ($urandom_range(0, 99) < 90) gap_left <= $urandom_range(1, 3);
				else gap_left <= $urandom_range(10, 40);
			end else in_valid <= 1'b0;
		end
	end

	task automatic check_field(string name, logic [19:0] exp_v, logic [19:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// receiver: compare each result beat, stall at random, hold off once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					answer_t e;
					e = answer_q.pop_front();
					check_field("signed_distance", e.sd, signed_distance);
					check_field("near_x", e.nx, near_x);
					check_field("near_y", e.ny, near_y);
					check_field("near_z", e.nz, near_z);
					check_field("on_axis", e.axis_hit, on_axis);
					check_field("bad_kind", e.bad, bad_kind);
					n_axis += e.axis_hit;
					n_bad += e.bad;
				end
				n_results++;
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!hold_done && n_results >= 150) begin
				hold_done <= 1'b1;
				hold_left <= 300;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 70) out_stall <= 1'b0;
			else if ($urandom_range(0, 99) < 90) out_stall <= 1'b1;
			else begin
				hold_left <= $urandom_range(10, 40);
				out_stall <= 1'b1;
			end
		end
	end

	function automatic logic [59:0] pack3(logic [19:0] x, logic [19:0] y, logic [19:0] z);
		return {z, y, x};
	endfunction

	// signed unit vector along one axis
	function automatic logic [59:0] unit_vec(int k, bit neg);
		logic [59:0] v;
		v = '0;
		v[k*20 +: 20] = neg ? -20'sd4096 : 20'sd4096;
		return v;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [59:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		pose_reg[idx] = (idx >= REG_RADIUS) ? {41'd0, v[18:0]} : v;
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every query is answered and the pipeline has drained
	task automatic drain();
		while (pending_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic add(logic [1:0] fn, logic [19:0] x, logic [19:0] y, logic [19:0] z);
		pending_q.push_back('{fn, x, y, z});
	endtask

	function automatic logic [19:0] near_val(logic [19:0] c, int span);
		return c + 20'($urandom_range(0, 2 * span) - span);
	endfunction

	// random queries: mostly near the origin, some along x through the origin, some anywhere or at the extremes
	task automatic add_random(int n);
		logic [1:0] fn;
		logic [19:0] ox, oy, oz;
		int r;
		ox = pose_reg[REG_ORIGIN][19:0];
		oy = pose_reg[REG_ORIGIN][39:20];
		oz = pose_reg[REG_ORIGIN][59:40];
		for (int i = 0; i < n; i++) begin
			fn = $urandom_range(0, 9) == 0 ? FN_BAD : 2'($urandom_range(0, 2));
			r = $urandom_range(0, 99);
			if (r < 65)
				add(fn, near_val(ox, 40000), near_val(oy, 40000), near_val(oz, 40000));
			else if (r < 80)
				add(fn, near_val(ox, 20000), oy, oz);
			else if (r < 95)
				add(fn, 20'($urandom), 20'($urandom), 20'($urandom));
			else
				add(fn, $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000,
					$urandom_range(0, 1) ? 20'h7FFFF : 20'h80000,
					$urandom_range(0, 1) ? 20'h7FFFF : 20'h80000);
		end
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pose_reg[REG_AXIS] = 60'd4096;
		pose_reg[REG_SIDE] = 60'd4294967296;
		pose_reg[REG_THIRD] = 60'd4503599627370496;
		pose_reg[REG_ORIGIN] = '0;
		pose_reg[REG_ANCHOR] = '0;
		pose_reg[REG_NORMAL] = 60'd4503599627370496;
		pose_reg[REG_RADIUS] = '0;
		pose_reg[REG_LENGTH] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// default pose: every kind, zero radius, extremes of the point
		add(FN_PLANE, 20'd0, 20'd0, 20'd0);
		add(FN_CAP, 20'd0, 20'd0, 20'd0);
		add(FN_HOLLOW, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
		add(FN_BAD, 20'h80000, 20'h80000, 20'h80000);
		add(FN_PLANE, 20'h80000, 20'h7FFFF, 20'h80000);
		add(FN_PLANE, 20'h7FFFF, 20'h80000, 20'h7FFFF);
		add_random(200);
		drain();

		// identity pose with a real capsule
		write_reg(REG_AXIS, unit_vec(0, 0));
		write_reg(REG_SIDE, unit_vec(1, 0));
		write_reg(REG_THIRD, unit_vec(2, 0));
		write_reg(REG_ORIGIN, pack3(20'd4096, -20'sd8192, 20'd2048));
		write_reg(REG_ANCHOR, pack3(20'd0, 20'd0, 20'd4096));
		write_reg(REG_NORMAL, unit_vec(2, 0));
		write_reg(REG_RADIUS, 60'd6144);
		write_reg(REG_LENGTH, {41'h1ABCD, 19'd16384});
		close_writes();
		// on the axis inside the span, at its ends, beyond them, and an exact hit
		add(FN_CAP, 20'd4096, -20'sd8192, 20'd2048);
		add(FN_HOLLOW, 20'd8192, -20'sd8192, 20'd2048);
		add(FN_CAP, 20'd12288, -20'sd8192, 20'd2048);
		add(FN_HOLLOW, 20'd40000, -20'sd8192, 20'd2048);
		add(FN_CAP, 20'd4096, -20'sd2048, 20'd2048);
		add(FN_HOLLOW, 20'd4096, -20'sd2048, 20'd2048);
		add(FN_PLANE, 20'd100, 20'd200, 20'd6144);
		add(FN_BAD, 20'd4096, -20'sd8192, 20'd2048);
		add(FN_CAP, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
		add(FN_HOLLOW, 20'h80000, 20'h80000, 20'h80000);
		add_random(400);
		drain();

		// permuted and reflected frames, random shape
		for (int ph = 0; ph < 3; ph++) begin
			k = $urandom_range(0, 2);
			write_reg(REG_AXIS, unit_vec(k, $urandom_range(0, 1)));
			write_reg(REG_SIDE, unit_vec((k + 1) % 3, $urandom_range(0, 1)));
			write_reg(REG_THIRD, unit_vec((k + 2) % 3, $urandom_range(0, 1)));
			write_reg(REG_ORIGIN, pack3(20'($urandom_range(0, 60000) - 30000),
				20'($urandom_range(0, 60000) - 30000), 20'($urandom_range(0, 60000) - 30000)));
			write_reg(REG_ANCHOR, pack3(20'($urandom_range(0, 8000) - 4000),
				20'($urandom_range(0, 8000) - 4000), 20'($urandom_range(0, 8000) - 4000)));
			write_reg(REG_NORMAL, pack3(20'($urandom_range(0, 4096) - 2048),
				20'($urandom_range(0, 4096) - 2048), 20'($urandom_range(0, 4096) - 2048)));
			write_reg(REG_RADIUS, 60'({$urandom, $urandom}));
			write_reg(REG_LENGTH, 60'($urandom_range(0, 40000)));
			close_writes();
			add_random(250);
			drain();
		end

		// extremes: full-range columns and vectors, largest and smallest shapes
		write_reg(REG_AXIS, pack3(20'h7FFFF, 20'h80000, 20'h7FFFF));
		write_reg(REG_SIDE, pack3(20'h80000, 20'h7FFFF, 20'h80000));
		write_reg(REG_THIRD, {60{1'b1}});
		write_reg(REG_ORIGIN, pack3(20'h80000, 20'h7FFFF, 20'h80000));
		write_reg(REG_ANCHOR, pack3(20'h7FFFF, 20'h7FFFF, 20'h80000));
		write_reg(REG_NORMAL, pack3(20'h80000, 20'h80000, 20'h7FFFF));
		write_reg(REG_RADIUS, 60'h7FFFF);
		write_reg(REG_LENGTH, 60'h7FFFF);
		close_writes();
		add_random(100);
		drain();
		write_reg(REG_AXIS, 60'({$urandom, $urandom}));
		write_reg(REG_SIDE, 60'({$urandom, $urandom}));
		write_reg(REG_THIRD, 60'({$urandom, $urandom}));
		write_reg(REG_ORIGIN, 60'({$urandom, $urandom}));
		write_reg(REG_ANCHOR, 60'({$urandom, $urandom}));
		write_reg(REG_NORMAL, 60'({$urandom, $urandom}));
		write_reg(REG_RADIUS, 60'd0);
		write_reg(REG_LENGTH, 60'd0);
		close_writes();
		add_random(100);
		drain();

		$display("Checked %0d results: %0d plane, %0d capsule, %0d hollow, %0d unsupported",
			n_results, kind_cnt[FN_PLANE], kind_cnt[FN_CAP], kind_cnt[FN_HOLLOW], kind_cnt[FN_BAD]);
		$display("On-axis fallbacks seen: %0d, across seven pose settings", n_axis);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#3200000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ppd_pkg.sv
rtl/ppd_sqrt.sv
rtl/ppd_div.sv
rtl/point_primitive_distance.sv
bench/point_primitive_distance_tb.sv
